// ===== hw/rtl/brp_pkg.sv =====
// ----------------------------------------------------------------------------
// brp_pkg: shared definitions for the binary request parser
// Event and request codes, configuration register indexes, reset values
// and the default length prefix size.
// ----------------------------------------------------------------------------
package brp_pkg;

    // Length prefix size in bytes (big-endian).
    localparam int unsigned PREFIX_BYTES_DEF = 4;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_KEY_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_PUT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_GET       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_DELETE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_STATS     = 3'd5;

    // Register reset values.
    localparam logic [31:0] MAX_KEY_LENGTH_RST   = 32'd65536;
    localparam logic [31:0] MAX_VALUE_LENGTH_RST = 32'd1048576;
    localparam logic [7:0]  OPCODE_PUT_RST       = 8'd11;
    localparam logic [7:0]  OPCODE_GET_RST       = 8'd13;
    localparam logic [7:0]  OPCODE_DELETE_RST    = 8'd12;
    localparam logic [7:0]  OPCODE_STATS_RST     = 8'd21;

    // Kind of a result item.
    typedef enum logic [1:0] {
        EV_KEY     = 2'd0,
        EV_VALUE   = 2'd1,
        EV_DONE    = 2'd2,
        EV_INVALID = 2'd3
    } event_kind_t;

    // Kind of the request being parsed.
    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_GET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_STATS  = 2'd3
    } request_kind_t;

endpackage

// ===== hw/rtl/binary_request_parser.sv =====
// ----------------------------------------------------------------------------
// binary_request_parser: byte-serial key/value request parser
// Splits a stream of put/get/delete/stats requests, with length-prefixed keys and
// values, into key and value byte items with request framing and error flags.
// ----------------------------------------------------------------------------
// Usage:
//   Request bytes enter on the s_ channel, one byte per item. Each byte
//   produces zero or one result item on the m_ channel: a key byte, a value
//   byte, a request-complete marker or an invalid-opcode marker. The last
//   result of each request has m_last_of_request set.
//   The parser state is updated in the cycle a byte is accepted and the
//   result lands in the output register, so a result appears in the cycle
//   after its byte. One byte is accepted every cycle while the output is
//   not stalled; the only storage in the path is the single output
//   register.
//   When the receiver stalls with a result pending, s_ready drops until the
//   result is taken; bytes that produce no result still wait for that slot.
//   Configuration writes on the cfg_ channel are always ready and take effect
//   at once; write them only while the parser is idle.
//   Reset (aresetn low, synchronous) returns the parser to waiting for an
//   opcode, empties the output register and restores the register defaults.
// ----------------------------------------------------------------------------
module binary_request_parser #(
    parameter int unsigned PREFIX_BYTES = brp_pkg::PREFIX_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [brp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [brp_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Request byte input.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_byte,

    // Result output.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_event_kind,
    output logic [7:0]                         m_data_byte,
    output logic [1:0]                         m_request_kind,
    output logic                               m_too_big,
    output logic [31:0]                        m_key_length,
    output logic [31:0]                        m_value_length,
    output logic                               m_last_of_request
);

    import brp_pkg::*;

    typedef enum logic [2:0] {
        ST_OPCODE  = 3'd0,
        ST_KEY_LEN = 3'd1,
        ST_KEY     = 3'd2,
        ST_VAL_LEN = 3'd3,
        ST_VAL     = 3'd4
    } stage_t;

    localparam logic [31:0] PREFIX_LEN = 32'(PREFIX_BYTES);

    // Configuration registers.
    logic [31:0] max_key_length_reg;
    logic [31:0] max_value_length_reg;
    logic [7:0]  opcode_put_reg;
    logic [7:0]  opcode_get_reg;
    logic [7:0]  opcode_delete_reg;
    logic [7:0]  opcode_stats_reg;

    // Parser state.
    stage_t        stage_reg, stage_next;
    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   prefix_reg, prefix_next;
    logic [31:0]   key_len_reg, key_len_next;
    logic [31:0]   val_len_reg, val_len_next;
    request_kind_t req_reg, req_next;
    logic          discard_reg, discard_next;
    logic          oversize_reg, oversize_next;

    // Output register.
    logic          m_valid_reg;
    event_kind_t   m_kind_reg;
    logic [7:0]    m_data_reg;
    request_kind_t m_req_reg;
    logic          m_too_big_reg;
    logic [31:0]   m_key_len_reg;
    logic [31:0]   m_val_len_reg;
    logic          m_last_reg;

    // Result produced by the current byte.
    logic          emit;
    event_kind_t   emit_kind;
    logic [7:0]    emit_data;
    logic          emit_last;

    logic          in_accept;
    logic [31:0]   pos_inc;
    logic [31:0]   prefix_acc;
    logic          prefix_done;
    logic          is_put;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Prefix accumulation saturates once another byte would overflow 32 bits.
    assign pos_inc     = pos_reg + 32'd1;
    assign prefix_acc  = (prefix_reg > 32'h00FF_FFFF) ? 32'hFFFF_FFFF
                                                      : {prefix_reg[23:0], s_in_byte};
    assign prefix_done = (pos_inc >= PREFIX_LEN);
    assign is_put      = (req_reg == REQ_PUT);

    // Next parser state and the result for the byte on the input.
    always_comb begin
        stage_next    = stage_reg;
        pos_next      = pos_reg;
        prefix_next   = prefix_reg;
        key_len_next  = key_len_reg;
        val_len_next  = val_len_reg;
        req_next      = req_reg;
        discard_next  = discard_reg;
        oversize_next = oversize_reg;
        emit          = 1'b0;
        emit_kind     = EV_DONE;
        emit_data     = 8'd0;
        emit_last     = 1'b0;

        unique case (stage_reg)
            ST_KEY_LEN: begin
                prefix_next = prefix_acc;
                pos_next    = pos_inc;
                if (prefix_done) begin
                    key_len_next = prefix_acc;
                    pos_next     = 32'd0;
                    prefix_next  = 32'd0;
                    stage_next   = ST_KEY;
                    if (prefix_acc > max_key_length_reg) begin
                        discard_next  = 1'b1;
                        oversize_next = 1'b1;
                    end
                    // An empty key ends the key field at once.
                    if (prefix_acc == 32'd0) begin
                        if (is_put) begin
                            stage_next = ST_VAL_LEN;
                        end else begin
                            stage_next = ST_OPCODE;
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                        end
                    end
                end
            end

            ST_KEY: begin
                pos_next = pos_inc;
                if (pos_inc >= key_len_reg) begin
                    pos_next    = 32'd0;
                    prefix_next = 32'd0;
                    stage_next  = is_put ? ST_VAL_LEN : ST_OPCODE;
                    if (discard_reg) begin
                        emit      = !is_put;
                        emit_last = 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_kind = EV_KEY;
                        emit_data = s_in_byte;
                        emit_last = !is_put;
                    end
                end else if (!discard_reg) begin
                    emit      = 1'b1;
                    emit_kind = EV_KEY;
                    emit_data = s_in_byte;
                end
            end

            ST_VAL_LEN: begin
                prefix_next = prefix_acc;
                pos_next    = pos_inc;
                if (prefix_done) begin
                    val_len_next = prefix_acc;
                    pos_next     = 32'd0;
                    prefix_next  = 32'd0;
                    stage_next   = ST_VAL;
                    if (prefix_acc > max_value_length_reg) begin
                        discard_next  = 1'b1;
                        oversize_next = 1'b1;
                    end
                    // An empty value completes the put here.
                    if (prefix_acc == 32'd0) begin
                        stage_next = ST_OPCODE;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                    end
                end
            end

            ST_VAL: begin
                pos_next = pos_inc;
                if (pos_inc >= val_len_reg) begin
                    stage_next = ST_OPCODE;
                    pos_next   = 32'd0;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    if (!discard_reg) begin
                        emit_kind = EV_VALUE;
                        emit_data = s_in_byte;
                    end
                end else if (!discard_reg) begin
                    emit      = 1'b1;
                    emit_kind = EV_VALUE;
                    emit_data = s_in_byte;
                end
            end

            default: begin
                // Waiting for an opcode; unused stage codes land here too.
                stage_next    = ST_KEY_LEN;
                pos_next      = 32'd0;
                prefix_next   = 32'd0;
                key_len_next  = 32'd0;
                val_len_next  = 32'd0;
                discard_next  = 1'b0;
                oversize_next = 1'b0;
                priority if (s_in_byte == opcode_put_reg) begin
                    req_next = REQ_PUT;
                end else if (s_in_byte == opcode_get_reg) begin
                    req_next = REQ_GET;
                end else if (s_in_byte == opcode_delete_reg) begin
                    req_next = REQ_DELETE;
                end else if (s_in_byte == opcode_stats_reg) begin
                    req_next   = REQ_STATS;
                    stage_next = ST_OPCODE;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                end else begin
                    req_next   = REQ_PUT;
                    stage_next = ST_OPCODE;
                    emit       = 1'b1;
                    emit_kind  = EV_INVALID;
                    emit_last  = 1'b1;
                end
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_key_length_reg   <= MAX_KEY_LENGTH_RST;
            max_value_length_reg <= MAX_VALUE_LENGTH_RST;
            opcode_put_reg       <= OPCODE_PUT_RST;
            opcode_get_reg       <= OPCODE_GET_RST;
            opcode_delete_reg    <= OPCODE_DELETE_RST;
            opcode_stats_reg     <= OPCODE_STATS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAX_KEY_LENGTH:   max_key_length_reg   <= cfg_data;
                CFG_MAX_VALUE_LENGTH: max_value_length_reg <= cfg_data;
                CFG_OPCODE_PUT:       opcode_put_reg       <= cfg_data[7:0];
                CFG_OPCODE_GET:       opcode_get_reg       <= cfg_data[7:0];
                CFG_OPCODE_DELETE:    opcode_delete_reg    <= cfg_data[7:0];
                CFG_OPCODE_STATS:     opcode_stats_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Parser state advances on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= ST_OPCODE;
            pos_reg      <= 32'd0;
            prefix_reg   <= 32'd0;
            key_len_reg  <= 32'd0;
            val_len_reg  <= 32'd0;
            req_reg      <= REQ_PUT;
            discard_reg  <= 1'b0;
            oversize_reg <= 1'b0;
        end else if (in_accept) begin
            stage_reg    <= stage_next;
            pos_reg      <= pos_next;
            prefix_reg   <= prefix_next;
            key_len_reg  <= key_len_next;
            val_len_reg  <= val_len_next;
            req_reg      <= req_next;
            discard_reg  <= discard_next;
            oversize_reg <= oversize_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload; fields report the state as updated by this byte.
    always_ff @(posedge aclk) begin
        if (in_accept && emit) begin
            m_kind_reg    <= emit_kind;
            m_data_reg    <= emit_data;
            m_req_reg     <= req_next;
            m_too_big_reg <= oversize_next;
            m_key_len_reg <= key_len_next;
            m_val_len_reg <= val_len_next;
            m_last_reg    <= emit_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_event_kind      = m_kind_reg;
    assign m_data_byte       = m_data_reg;
    assign m_request_kind    = m_req_reg;
    assign m_too_big         = m_too_big_reg;
    assign m_key_length      = m_key_len_reg;
    assign m_value_length    = m_val_len_reg;
    assign m_last_of_request = m_last_reg;

    // Discarding only ever follows an oversize length.
    a_discard_implies_oversize: assert property (
        @(posedge aclk) disable iff (!aresetn)
        discard_reg |-> oversize_reg
    ) else $error("discarding without an oversize length");

    // The prefix byte count never reaches the prefix size between bytes.
    a_prefix_pos_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (stage_reg == ST_KEY_LEN || stage_reg == ST_VAL_LEN) |-> (pos_reg < PREFIX_LEN)
    ) else $error("prefix byte position out of range");

    // Key and value bytes are never passed out of a discarded request.
    a_data_not_too_big: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == EV_KEY || m_kind_reg == EV_VALUE)) |-> !m_too_big_reg
    ) else $error("data byte emitted from an oversize request");

    // A stats opcode yields a complete marker in the next cycle.
    a_stats_done: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (in_accept && stage_reg == ST_OPCODE && s_in_byte == opcode_stats_reg
         && s_in_byte != opcode_put_reg && s_in_byte != opcode_get_reg
         && s_in_byte != opcode_delete_reg)
        |=> (m_valid_reg && m_kind_reg == EV_DONE && m_req_reg == REQ_STATS && m_last_reg)
    ) else $error("stats request did not complete");

    // An invalid opcode result is a final result with no decoded lengths.
    a_invalid_shape: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == EV_INVALID)
        |-> (m_last_reg && m_req_reg == REQ_PUT && m_key_len_reg == 32'd0
             && m_val_len_reg == 32'd0 && !m_too_big_reg)
    ) else $error("malformed invalid-opcode result");

endmodule
